>>> sv/lbpc_pkg.sv
// Shared constants and types for the Liang-Barsky polygon clip unit.
package lbpc_pkg;

	localparam int CFG_INDEX_BITS = 2;

	localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_LEFT   = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_RIGHT  = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_BOTTOM = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_TOP    = 2'd3;

	localparam int WIN_LO_RESET = 0;
	localparam int WIN_HI_RESET = 255;

	// Kind of an edge parameter; the codes are ordered so that a plain compare works.
	localparam logic [1:0] KIND_NINF = 2'd0;
	localparam logic [1:0] KIND_FIN  = 2'd1;
	localparam logic [1:0] KIND_PINF = 2'd2;

	// Which pair of parameters the shared compare works on.
	localparam logic [1:0] CMP_IN    = 2'd0;
	localparam logic [1:0] CMP_OUT   = 2'd1;
	localparam logic [1:0] CMP_CROSS = 2'd2;

	typedef enum logic [13:0] {
		ST_IDLE   = 14'b00000000000001,
		ST_SETUP  = 14'b00000000000010,
		ST_MUL1   = 14'b00000000000100,
		ST_MUL2   = 14'b00000000001000,
		ST_CMP    = 14'b00000000010000,
		ST_DEC1   = 14'b00000000100000,
		ST_DEC2   = 14'b00000001000000,
		ST_DEC3   = 14'b00000010000000,
		ST_EXIT   = 14'b00000100000000,
		ST_IMUL   = 14'b00001000000000,
		ST_ISTART = 14'b00010000000000,
		ST_IDIV   = 14'b00100000000000,
		ST_IEMIT  = 14'b01000000000000,
		ST_LAST   = 14'b10000000000000
	} lbpc_state_t;

endpackage

>>> sv/lbpc_if.sv
// Valid/ready channels for polygon vertices and clipped vertices.
interface lbpc_vtx_if #(parameter int COORD_BITS = 16);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] vertex_x;
	logic signed [COORD_BITS-1:0] vertex_y;
	logic                         first_vertex;
	logic                         last_vertex;

	modport source (output valid, vertex_x, vertex_y, first_vertex, last_vertex, input ready);
	modport sink (input valid, vertex_x, vertex_y, first_vertex, last_vertex, output ready);
endinterface

interface lbpc_clip_if #(parameter int COORD_BITS = 16);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] clip_x;
	logic signed [COORD_BITS-1:0] clip_y;
	logic                         end_of_polygon;
	logic                         is_empty;

	modport source (output valid, clip_x, clip_y, end_of_polygon, is_empty, input ready);
	modport sink (input valid, clip_x, clip_y, end_of_polygon, is_empty, output ready);
endinterface

>>> sv/lbpc_div.sv
// Restoring divider, one quotient bit per cycle, for a quotient known to fit WIDTH bits.
module lbpc_div #(
	parameter int WIDTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [2*WIDTH-1:0] dividend,
	input  logic [WIDTH-1:0]   divisor,
	output logic               done,
	output logic [WIDTH-1:0]   quot,
	output logic               rem_nz
);

	localparam int CNT_BITS = $clog2(WIDTH + 1);

	logic [CNT_BITS-1:0] cnt_q;
	logic                busy_q;
	logic                done_q;
	logic [WIDTH-1:0]    rem_q;
	logic [WIDTH-1:0]    quo_q;
	logic [WIDTH-1:0]    dsr_q;
	logic [WIDTH:0]      trial;
	logic                fits;
	logic [WIDTH:0]      diff;

	assign trial = {rem_q, quo_q[WIDTH-1]};
	assign fits  = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CNT_BITS'(WIDTH);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The upper half of the dividend is below the divisor, so it seeds the remainder.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[2*WIDTH-1:WIDTH];
			quo_q <= dividend[WIDTH-1:0];
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
			quo_q <= {quo_q[WIDTH-2:0], fits};
		end
	end

	assign done   = done_q;
	assign quot   = quo_q;
	assign rem_nz = rem_q != '0;

endmodule

>>> sv/liang_barsky_polygon_clip_unit.sv
// Liang-Barsky polygon clipper: one vertex in, zero to four clipped vertices out.
// A first vertex uses neither; the time an edge takes is set by the single shared
// multiplier and the bit-serial divider.
// A new vertex is taken only once the previous one is fully handled; the result
// register holds one vertex and the sequencer waits on it when it is full.
// Reset is asynchronous and active low; it restores the default window and clears state.
module liang_barsky_polygon_clip_unit #(
	parameter int COORD_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	lbpc_vtx_if.sink                               vertex,
	lbpc_clip_if.source                            clip,
	input  logic                                   cfg_wr_en,
	input  logic [lbpc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [COORD_BITS-1:0]                  cfg_wr_data
);

	localparam int W  = COORD_BITS;
	localparam int PW = 2 * W;

	typedef logic signed [W-1:0] crd_t;
	typedef logic signed [W:0]   wide_t;
	typedef struct packed {
		logic [1:0]      kind;
		logic signed [W:0] n;
		logic [W-1:0]    d;
	} tpar_t;

	function automatic tpar_t mk_t(input wide_t num, input wide_t den);
		tpar_t t;
		wide_t dn;
		dn     = den[W] ? -den : den;
		t.kind = lbpc_pkg::KIND_FIN;
		t.n    = den[W] ? -num : num;
		t.d    = dn[W-1:0];
		return t;
	endfunction

	function automatic tpar_t inf_t(input logic [1:0] k);
		tpar_t t;
		t.kind = k;
		t.n    = '0;
		t.d    = W'(1);
		return t;
	endfunction

	function automatic logic [W-1:0] mag(input wide_t v);
		wide_t m;
		m = v[W] ? -v : v;
		return m[W-1:0];
	endfunction

	function automatic logic t_pos(input tpar_t t);
		return (t.kind == lbpc_pkg::KIND_PINF) ||
			(t.kind == lbpc_pkg::KIND_FIN && t.n > 0);
	endfunction

	function automatic logic t_gt1(input tpar_t t);
		return (t.kind == lbpc_pkg::KIND_PINF) ||
			(t.kind == lbpc_pkg::KIND_FIN && t.n > $signed({1'b0, t.d}));
	endfunction

	function automatic logic t_lt1(input tpar_t t);
		return (t.kind == lbpc_pkg::KIND_NINF) ||
			(t.kind == lbpc_pkg::KIND_FIN && t.n < $signed({1'b0, t.d}));
	endfunction

	function automatic wide_t ext(input crd_t v);
		return $signed({v[W-1], v});
	endfunction

	lbpc_pkg::lbpc_state_t state_q, state_d;

	crd_t win_left_q, win_right_q, win_bottom_q, win_top_q;
	crd_t prev_x_q, prev_y_q, first_out_x_q, first_out_y_q;
	logic any_output_q, last_q;
	crd_t x1_q, y1_q, x2_q, y2_q;
	tpar_t tinx_q, tiny_q, toutx_q, touty_q;
	logic [PW-1:0] prod1_q, prod2_q;
	logic [1:0] cmp_id_q, cmp_id_d;
	logic ip_exit_q, ip_exit_d;
	logic in_lt_q, in_gt_q, out_lt_q, cross_le_q;
	logic out_valid_q, out_eop_q, out_emp_q;
	crd_t out_x_q, out_y_q;

	wide_t dx, dy;
	logic  x_fwd, y_fwd, x_inside, y_inside;
	crd_t  xin, xout, yin, yout;
	tpar_t tinx_d, tiny_d, toutx_d, touty_d;
	tpar_t tin1, tin2, tout1, cmp_a, cmp_b, ip_t;
	logic  ip_use_y;
	crd_t  ip_base;
	wide_t ip_delta;
	logic [W-1:0]  mul_a, mul_b;
	logic [PW-1:0] mul_p;
	logic signed [PW:0] s1, s2;
	logic cmp_lt, cmp_gt;
	logic div_start, div_done, div_rem_nz;
	logic [W-1:0] div_quot;
	logic signed [W+1:0] ip_v;
	logic ip_neg;
	logic in_xfer, out_free;
	logic push, push_track, push_eop, push_emp;
	crd_t push_x, push_y;

	assign in_xfer  = vertex.valid && vertex.ready;
	assign out_free = !out_valid_q || clip.ready;

	// Edge geometry, straight from the edge registers.
	assign dx       = ext(x2_q) - ext(x1_q);
	assign dy       = ext(y2_q) - ext(y1_q);
	assign x_fwd    = (dx > 0) || (dx == 0 && x1_q > win_right_q);
	assign y_fwd    = (dy > 0) || (dy == 0 && y1_q > win_top_q);
	assign xin      = x_fwd ? win_left_q : win_right_q;
	assign xout     = x_fwd ? win_right_q : win_left_q;
	assign yin      = y_fwd ? win_bottom_q : win_top_q;
	assign yout     = y_fwd ? win_top_q : win_bottom_q;
	assign x_inside = (win_left_q <= x1_q) && (x1_q <= win_right_q);
	assign y_inside = (win_bottom_q <= y1_q) && (y1_q <= win_top_q);

	assign tinx_d  = (dx != 0) ? mk_t(ext(xin) - ext(x1_q), dx) : inf_t(lbpc_pkg::KIND_NINF);
	assign tiny_d  = (dy != 0) ? mk_t(ext(yin) - ext(y1_q), dy) : inf_t(lbpc_pkg::KIND_NINF);
	assign toutx_d = (dx != 0) ? mk_t(ext(xout) - ext(x1_q), dx) :
		inf_t(x_inside ? lbpc_pkg::KIND_PINF : lbpc_pkg::KIND_NINF);
	assign touty_d = (dy != 0) ? mk_t(ext(yout) - ext(y1_q), dy) :
		inf_t(y_inside ? lbpc_pkg::KIND_PINF : lbpc_pkg::KIND_NINF);

	assign tin1  = in_lt_q ? tinx_q : tiny_q;
	assign tin2  = in_lt_q ? tiny_q : tinx_q;
	assign tout1 = out_lt_q ? toutx_q : touty_q;

	always_comb begin
		case (cmp_id_q)
			lbpc_pkg::CMP_IN: begin
				cmp_a = tinx_q;
				cmp_b = tiny_q;
			end
			lbpc_pkg::CMP_OUT: begin
				cmp_a = toutx_q;
				cmp_b = touty_q;
			end
			default: begin
				cmp_a = tin2;
				cmp_b = tout1;
			end
		endcase
	end

	// Intersection operands: entry point follows the later entry, exit the earlier exit.
	assign ip_use_y = ip_exit_q ? out_lt_q : in_gt_q;
	assign ip_t     = ip_exit_q ? (out_lt_q ? toutx_q : touty_q) : (in_gt_q ? tinx_q : tiny_q);
	assign ip_base  = ip_use_y ? y1_q : x1_q;
	assign ip_delta = ip_use_y ? dy : dx;

	// The one shared multiplier.
	always_comb begin
		mul_a = mag(ip_t.n);
		mul_b = mag(ip_delta);
		if (state_q == lbpc_pkg::ST_MUL1) begin
			mul_a = mag(cmp_a.n);
			mul_b = cmp_b.d;
		end else if (state_q == lbpc_pkg::ST_MUL2) begin
			mul_a = mag(cmp_b.n);
			mul_b = cmp_a.d;
		end
	end
	assign mul_p = PW'(mul_a) * PW'(mul_b);

	// Exact compare of a.n/a.d against b.n/b.d through the cross products.
	always_comb begin
		s1 = cmp_a.n[W] ? -$signed({1'b0, prod1_q}) : $signed({1'b0, prod1_q});
		s2 = cmp_b.n[W] ? -$signed({1'b0, prod2_q}) : $signed({1'b0, prod2_q});
		if (cmp_a.kind != cmp_b.kind) begin
			cmp_lt = cmp_a.kind < cmp_b.kind;
			cmp_gt = !cmp_lt;
		end else if (cmp_a.kind != lbpc_pkg::KIND_FIN) begin
			cmp_lt = 1'b0;
			cmp_gt = 1'b0;
		end else begin
			cmp_lt = s1 < s2;
			cmp_gt = s1 > s2;
		end
	end

	// base + t*delta truncated toward zero, from quotient and remainder.
	always_comb begin
		ip_neg = (prod1_q != '0) && (ip_t.n[W] != ip_delta[W]);
		if (!ip_neg) begin
			ip_v = $signed({{2{ip_base[W-1]}}, ip_base}) + $signed({2'b00, div_quot});
			if (ip_v < 0 && div_rem_nz) begin
				ip_v = ip_v + (W+2)'(1);
			end
		end else begin
			ip_v = $signed({{2{ip_base[W-1]}}, ip_base}) - $signed({2'b00, div_quot});
			if (ip_v >= 1 && div_rem_nz) begin
				ip_v = ip_v - (W+2)'(1);
			end
		end
	end

	lbpc_div #(.WIDTH(W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod1_q),
		.divisor  (ip_t.d),
		.done     (div_done),
		.quot     (div_quot),
		.rem_nz   (div_rem_nz)
	);

	// Sequencer.
	always_comb begin
		state_d    = state_q;
		cmp_id_d   = cmp_id_q;
		ip_exit_d  = ip_exit_q;
		div_start  = 1'b0;
		push       = 1'b0;
		push_track = 1'b1;
		push_eop   = 1'b0;
		push_emp   = 1'b0;
		push_x     = xin;
		push_y     = yin;
		case (state_q)
			lbpc_pkg::ST_IDLE: begin
				if (in_xfer) begin
					state_d = vertex.first_vertex ? lbpc_pkg::ST_LAST : lbpc_pkg::ST_SETUP;
				end
			end
			lbpc_pkg::ST_SETUP: begin
				cmp_id_d = lbpc_pkg::CMP_IN;
				state_d  = lbpc_pkg::ST_MUL1;
			end
			lbpc_pkg::ST_MUL1: state_d = lbpc_pkg::ST_MUL2;
			lbpc_pkg::ST_MUL2: state_d = lbpc_pkg::ST_CMP;
			lbpc_pkg::ST_CMP: begin
				case (cmp_id_q)
					lbpc_pkg::CMP_IN:  state_d = lbpc_pkg::ST_DEC1;
					lbpc_pkg::CMP_OUT: state_d = lbpc_pkg::ST_DEC2;
					default:           state_d = lbpc_pkg::ST_DEC3;
				endcase
			end
			lbpc_pkg::ST_DEC1: begin
				if (t_gt1(tin1)) begin
					state_d = lbpc_pkg::ST_LAST;
				end else if (!t_pos(tin1) || out_free) begin
					push = t_pos(tin1);
					if (t_gt1(tin2)) begin
						state_d = lbpc_pkg::ST_LAST;
					end else begin
						cmp_id_d = lbpc_pkg::CMP_OUT;
						state_d  = lbpc_pkg::ST_MUL1;
					end
				end
			end
			lbpc_pkg::ST_DEC2: begin
				if (!(t_pos(tin2) || t_pos(tout1))) begin
					state_d = lbpc_pkg::ST_LAST;
				end else begin
					cmp_id_d = lbpc_pkg::CMP_CROSS;
					state_d  = lbpc_pkg::ST_MUL1;
				end
			end
			lbpc_pkg::ST_DEC3: begin
				if (cross_le_q) begin
					if (t_pos(tin2)) begin
						ip_exit_d = 1'b0;
						state_d   = lbpc_pkg::ST_IMUL;
					end else begin
						state_d = lbpc_pkg::ST_EXIT;
					end
				end else if (out_free) begin
					// The edge passes a window corner only.
					push    = 1'b1;
					push_x  = in_gt_q ? xin : xout;
					push_y  = in_gt_q ? yout : yin;
					state_d = lbpc_pkg::ST_LAST;
				end
			end
			lbpc_pkg::ST_EXIT: begin
				if (t_lt1(tout1)) begin
					ip_exit_d = 1'b1;
					state_d   = lbpc_pkg::ST_IMUL;
				end else if (out_free) begin
					push    = 1'b1;
					push_x  = x2_q;
					push_y  = y2_q;
					state_d = lbpc_pkg::ST_LAST;
				end
			end
			lbpc_pkg::ST_IMUL: state_d = lbpc_pkg::ST_ISTART;
			lbpc_pkg::ST_ISTART: begin
				div_start = 1'b1;
				state_d   = lbpc_pkg::ST_IDIV;
			end
			lbpc_pkg::ST_IDIV: begin
				if (div_done) begin
					state_d = lbpc_pkg::ST_IEMIT;
				end
			end
			lbpc_pkg::ST_IEMIT: begin
				if (out_free) begin
					push    = 1'b1;
					push_x  = ip_use_y ? (ip_exit_q ? xout : xin) : ip_v[W-1:0];
					push_y  = ip_use_y ? ip_v[W-1:0] : (ip_exit_q ? yout : yin);
					state_d = ip_exit_q ? lbpc_pkg::ST_LAST : lbpc_pkg::ST_EXIT;
				end
			end
			lbpc_pkg::ST_LAST: begin
				if (!last_q) begin
					state_d = lbpc_pkg::ST_IDLE;
				end else if (out_free) begin
					push       = 1'b1;
					push_track = 1'b0;
					push_eop   = 1'b1;
					push_emp   = !any_output_q;
					push_x     = any_output_q ? first_out_x_q : '0;
					push_y     = any_output_q ? first_out_y_q : '0;
					state_d    = lbpc_pkg::ST_IDLE;
				end
			end
			default: state_d = lbpc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= lbpc_pkg::ST_IDLE;
			win_left_q    <= W'(lbpc_pkg::WIN_LO_RESET);
			win_right_q   <= W'(lbpc_pkg::WIN_HI_RESET);
			win_bottom_q  <= W'(lbpc_pkg::WIN_LO_RESET);
			win_top_q     <= W'(lbpc_pkg::WIN_HI_RESET);
			prev_x_q      <= '0;
			prev_y_q      <= '0;
			first_out_x_q <= '0;
			first_out_y_q <= '0;
			any_output_q  <= 1'b0;
			last_q        <= 1'b0;
			cmp_id_q      <= lbpc_pkg::CMP_IN;
			ip_exit_q     <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q   <= state_d;
			cmp_id_q  <= cmp_id_d;
			ip_exit_q <= ip_exit_d;
			if (cfg_wr_en) begin
				case (cfg_index)
					lbpc_pkg::REG_WINDOW_LEFT:   win_left_q   <= cfg_wr_data;
					lbpc_pkg::REG_WINDOW_RIGHT:  win_right_q  <= cfg_wr_data;
					lbpc_pkg::REG_WINDOW_BOTTOM: win_bottom_q <= cfg_wr_data;
					lbpc_pkg::REG_WINDOW_TOP:    win_top_q    <= cfg_wr_data;
					default: ;
				endcase
			end
			if (in_xfer) begin
				prev_x_q <= vertex.vertex_x;
				prev_y_q <= vertex.vertex_y;
				last_q   <= vertex.last_vertex;
				if (vertex.first_vertex) begin
					any_output_q  <= 1'b0;
					first_out_x_q <= '0;
					first_out_y_q <= '0;
				end
			end
			if (push && push_track && !any_output_q) begin
				any_output_q  <= 1'b1;
				first_out_x_q <= push_x;
				first_out_y_q <= push_y;
			end
			if (push && !push_track) begin
				any_output_q <= 1'b0;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (clip.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			x1_q <= prev_x_q;
			y1_q <= prev_y_q;
			x2_q <= vertex.vertex_x;
			y2_q <= vertex.vertex_y;
		end
		if (state_q == lbpc_pkg::ST_SETUP) begin
			tinx_q  <= tinx_d;
			tiny_q  <= tiny_d;
			toutx_q <= toutx_d;
			touty_q <= touty_d;
		end
		if (state_q inside {lbpc_pkg::ST_MUL1, lbpc_pkg::ST_IMUL}) begin
			prod1_q <= mul_p;
		end
		if (state_q == lbpc_pkg::ST_MUL2) begin
			prod2_q <= mul_p;
		end
		if (state_q == lbpc_pkg::ST_CMP) begin
			case (cmp_id_q)
				lbpc_pkg::CMP_IN: begin
					in_lt_q <= cmp_lt;
					in_gt_q <= cmp_gt;
				end
				lbpc_pkg::CMP_OUT: out_lt_q <= cmp_lt;
				default:           cross_le_q <= !cmp_gt;
			endcase
		end
		if (push) begin
			out_x_q   <= push_x;
			out_y_q   <= push_y;
			out_eop_q <= push_eop;
			out_emp_q <= push_emp;
		end
	end

	assign vertex.ready        = state_q == lbpc_pkg::ST_IDLE;
	assign clip.valid          = out_valid_q;
	assign clip.clip_x         = out_x_q;
	assign clip.clip_y         = out_y_q;
	assign clip.end_of_polygon = out_eop_q;
	assign clip.is_empty       = out_emp_q;

endmodule

>>> sv/lbpc_chk.sv
// Port-level checks for the polygon clip unit, bound to its top level.
module lbpc_chk #(
	parameter int COORD_BITS = 16
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [COORD_BITS-1:0] out_x,
	input logic [COORD_BITS-1:0] out_y,
	input logic                  out_eop,
	input logic                  out_emp
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("clipped vertex dropped before its transfer");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_x) && $stable(out_y) &&
			$stable(out_eop) && $stable(out_emp))
		else $error("stalled clipped vertex changed");

	a_empty_marker: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_emp |-> out_eop && out_x == '0 && out_y == '0)
		else $error("empty marker is malformed");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("vertex taken while the previous one is still in work");

endmodule

bind liang_barsky_polygon_clip_unit lbpc_chk #(.COORD_BITS(COORD_BITS)) u_lbpc_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (vertex.valid),
	.in_ready  (vertex.ready),
	.out_valid (clip.valid),
	.out_ready (clip.ready),
	.out_x     (clip.clip_x),
	.out_y     (clip.clip_y),
	.out_eop   (clip.end_of_polygon),
	.out_emp   (clip.is_empty)
);

>>> tb/tb.sv
// Self-checking testbench for the Liang-Barsky polygon clip unit.
`timescale 1ns / 100ps

module tb;

	localparam int CB = 16;
	localparam int SETTLE_CYCLES = 4 * CB + 60;
	localparam int CYCLE_LIMIT = 600000;

	typedef struct {
		logic signed [CB-1:0] x;
		logic signed [CB-1:0] y;
		logic                 first;
		logic                 last;
	} vertex_t;

	typedef struct {
		logic signed [CB-1:0] x;
		logic signed [CB-1:0] y;
		logic                 eop;
		logic                 emp;
	} clip_vtx_t;

	typedef struct {
		int     kind;
		longint n;
		longint d;
	} edge_par_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [lbpc_pkg::CFG_INDEX_BITS-1:0] cfg_index;
	logic [CB-1:0] cfg_wr_data;

	lbpc_vtx_if #(.COORD_BITS(CB)) vin ();
	lbpc_clip_if #(.COORD_BITS(CB)) vout ();

	liang_barsky_polygon_clip_unit #(.COORD_BITS(CB)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.vertex(vin),
		.clip(vout),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wr_data(cfg_wr_data)
	);

	vertex_t   pending_vertices[$];
	clip_vtx_t expected_clips[$];

	longint win_l, win_r, win_b, win_t;
	longint last_x, last_y, open_x, open_y;
	bit     have_output;

	int  errors;
	int  cycles;
	bit  no_idle;
	bit  hold_req;
	bit  hold_taken;
	int  hold_cnt;
	bit  in_xfer;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic edge_par_t par_fin(longint num, longint den);
		edge_par_t t;
		if (den < 0) begin
			num = -num;
			den = -den;
		end
		t.kind = 0;
		t.n = num;
		t.d = den;
		return t;
	endfunction

	function automatic edge_par_t par_inf(int k);
		edge_par_t t;
		t.kind = k;
		t.n = 0;
		t.d = 1;
		return t;
	endfunction

	function automatic int par_cmp(edge_par_t a, edge_par_t b);
		longint l, r;
		if (a.kind != b.kind)
			return (a.kind < b.kind) ? -1 : 1;
		if (a.kind != 0)
			return 0;
		l = a.n * b.d;
		r = b.n * a.d;
		if (l == r)
			return 0;
		return (l < r) ? -1 : 1;
	endfunction

	// Exact base + t*delta, truncated toward zero.
	function automatic longint lerp_trunc(longint base, edge_par_t t, longint delta);
		longint m, q, r, v;
		bit neg;
		if (t.kind != 0 || t.d <= 0)
			return base;
		m = t.n * delta;
		neg = m < 0;
		if (neg)
			m = -m;
		q = m / t.d;
		r = m % t.d;
		if (!neg) begin
			v = base + q;
			if (v < 0 && r != 0)
				v = v + 1;
		end else begin
			v = base - q;
			if (v >= 1 && r != 0)
				v = v - 1;
		end
		return v;
	endfunction

	function automatic void push_clip(longint x, longint y, bit eop, bit emp);
		clip_vtx_t c;
		c.x = x[CB-1:0];
		c.y = y[CB-1:0];
		c.eop = eop;
		c.emp = emp;
		expected_clips.push_back(c);
	endfunction

	function automatic void emit_vertex(longint x, longint y);
		if (!have_output) begin
			open_x = x;
			open_y = y;
			have_output = 1'b1;
		end
		push_clip(x, y, 1'b0, 1'b0);
	endfunction

	function automatic void clip_segment(longint x1, longint y1, longint x2, longint y2);
		longint dx, dy, xin, xout, yin, yout;
		edge_par_t tinx, tiny, tin1, tin2, toutx, touty, tout1, zero, one;
		dx = x2 - x1;
		dy = y2 - y1;
		zero = par_fin(0, 1);
		one = par_fin(1, 1);
		if (dx > 0 || (dx == 0 && x1 > win_r)) begin
			xin = win_l;
			xout = win_r;
		end else begin
			xin = win_r;
			xout = win_l;
		end
		if (dy > 0 || (dy == 0 && y1 > win_t)) begin
			yin = win_b;
			yout = win_t;
		end else begin
			yin = win_t;
			yout = win_b;
		end
		tinx = (dx != 0) ? par_fin(xin - x1, dx) : par_inf(-1);
		tiny = (dy != 0) ? par_fin(yin - y1, dy) : par_inf(-1);
		if (par_cmp(tinx, tiny) < 0) begin
			tin1 = tinx;
			tin2 = tiny;
		end else begin
			tin1 = tiny;
			tin2 = tinx;
		end
		if (par_cmp(tin1, one) > 0)
			return;
		if (par_cmp(zero, tin1) < 0)
			emit_vertex(xin, yin);
		if (par_cmp(tin2, one) > 0)
			return;
		if (dx != 0)
			toutx = par_fin(xout - x1, dx);
		else
			toutx = par_inf((win_l <= x1 && x1 <= win_r) ? 1 : -1);
		if (dy != 0)
			touty = par_fin(yout - y1, dy);
		else
			touty = par_inf((win_b <= y1 && y1 <= win_t) ? 1 : -1);
		tout1 = (par_cmp(toutx, touty) < 0) ? toutx : touty;
		if (!(par_cmp(zero, tin2) < 0 || par_cmp(zero, tout1) < 0))
			return;
		if (par_cmp(tin2, tout1) <= 0) begin
			if (par_cmp(zero, tin2) < 0) begin
				if (par_cmp(tinx, tiny) > 0)
					emit_vertex(xin, lerp_trunc(y1, tinx, dy));
				else
					emit_vertex(lerp_trunc(x1, tiny, dx), yin);
			end
			if (par_cmp(tout1, one) < 0) begin
				if (par_cmp(toutx, touty) < 0)
					emit_vertex(xout, lerp_trunc(y1, toutx, dy));
				else
					emit_vertex(lerp_trunc(x1, touty, dx), yout);
			end else begin
				emit_vertex(x2, y2);
			end
		end else begin
			if (par_cmp(tinx, tiny) > 0)
				emit_vertex(xin, yout);
			else
				emit_vertex(xout, yin);
		end
	endfunction

	function automatic void predict_vertex(vertex_t v);
		longint x, y;
		x = v.x;
		y = v.y;
		if (v.first) begin
			have_output = 1'b0;
			open_x = 0;
			open_y = 0;
		end else begin
			clip_segment(last_x, last_y, x, y);
		end
		last_x = x;
		last_y = y;
		if (v.last) begin
			if (have_output)
				push_clip(open_x, open_y, 1'b1, 1'b0);
			else
				push_clip(0, 0, 1'b1, 1'b1);
			have_output = 1'b0;
		end
	endfunction

	function automatic void add_vertex(longint x, longint y, bit first, bit last);
		vertex_t v;
		v.x = x[CB-1:0];
		v.y = y[CB-1:0];
		v.first = first;
		v.last = last;
		pending_vertices.push_back(v);
	endfunction

	// Coordinates mostly land near the current window so that edges cross it.
	function automatic longint rand_coord(longint a, longint b);
		longint lo, hi;
		if ($urandom_range(0, 4) == 0)
			return longint'($signed(16'($urandom())));
		lo = ((a < b) ? a : b) - 64;
		hi = ((a > b) ? a : b) + 64;
		if (lo < -32768)
			lo = -32768;
		if (hi > 32767)
			hi = 32767;
		return lo + longint'($urandom_range(0, int'(hi - lo)));
	endfunction

	function automatic void add_random_items(int count);
		int n, k;
		longint fx, fy;
		n = 0;
		while (n < count) begin
			if ($urandom_range(0, 9) == 0) begin
				add_vertex(rand_coord(win_l, win_r), rand_coord(win_b, win_t),
					$urandom_range(0, 1), $urandom_range(0, 1));
				n++;
			end else begin
				fx = rand_coord(win_l, win_r);
				fy = rand_coord(win_b, win_t);
				add_vertex(fx, fy, 1'b1, 1'b0);
				k = $urandom_range(1, 5);
				repeat (k)
					add_vertex(rand_coord(win_l, win_r), rand_coord(win_b, win_t), 1'b0, 1'b0);
				add_vertex(fx, fy, 1'b0, 1'b1);
				n += k + 2;
			end
		end
	endfunction

	task automatic write_reg(logic [lbpc_pkg::CFG_INDEX_BITS-1:0] idx, longint val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wr_data <= val[CB-1:0];
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic set_window(longint l, longint r, longint b, longint t);
		write_reg(lbpc_pkg::REG_WINDOW_LEFT, l);
		write_reg(lbpc_pkg::REG_WINDOW_RIGHT, r);
		write_reg(lbpc_pkg::REG_WINDOW_BOTTOM, b);
		write_reg(lbpc_pkg::REG_WINDOW_TOP, t);
		win_l = l;
		win_r = r;
		win_b = b;
		win_t = t;
	endtask

	task automatic drain();
		while (pending_vertices.size() != 0 || vin.valid || expected_clips.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Driver: a vertex stays on the bus until its transfer.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vin.valid <= 1'b0;
		end else if (!vin.valid || in_xfer) begin
			if (pending_vertices.size() != 0 && (no_idle || $urandom_range(0, 99) >= 18)) begin
				vertex_t v;
				v = pending_vertices.pop_front();
				vin.valid <= 1'b1;
				vin.vertex_x <= v.x;
				vin.vertex_y <= v.y;
				vin.first_vertex <= v.first;
				vin.last_vertex <= v.last;
			end else begin
				vin.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vout.ready <= 1'b0;
			hold_cnt <= 0;
			hold_taken <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			vout.ready <= 1'b0;
		end else if (hold_req && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_cnt <= 400;
			vout.ready <= 1'b0;
		end else begin
			vout.ready <= no_idle || $urandom_range(0, 99) >= 18;
		end
	end

	// Monitor: predicts on input transfers and checks output transfers.
	always @(posedge clk) begin
		in_xfer <= arst_n && vin.valid && vin.ready;
		if (arst_n) begin
			cycles <= cycles + 1;
			if (cycles > CYCLE_LIMIT) begin
				$display("tb: errors");
				$finish;
			end
			if (vin.valid && vin.ready) begin
				vertex_t v;
				v.x = vin.vertex_x;
				v.y = vin.vertex_y;
				v.first = vin.first_vertex;
				v.last = vin.last_vertex;
				predict_vertex(v);
			end
			if (vout.valid && vout.ready) begin
				clip_vtx_t e;
				if (expected_clips.size() == 0) begin
					$display("%0t: unexpected clip vertex x=%0d y=%0d eop=%b empty=%b", $time,
						vout.clip_x, vout.clip_y, vout.end_of_polygon, vout.is_empty);
					errors++;
				end else begin
					e = expected_clips.pop_front();
					if (vout.clip_x !== e.x) begin
						$display("%0t: clip_x expected %0d actual %0d", $time, e.x, vout.clip_x);
						errors++;
					end
					if (vout.clip_y !== e.y) begin
						$display("%0t: clip_y expected %0d actual %0d", $time, e.y, vout.clip_y);
						errors++;
					end
					if (vout.end_of_polygon !== e.eop) begin
						$display("%0t: end_of_polygon expected %b actual %b", $time, e.eop,
							vout.end_of_polygon);
						errors++;
					end
					if (vout.is_empty !== e.emp) begin
						$display("%0t: is_empty expected %b actual %b", $time, e.emp,
							vout.is_empty);
						errors++;
					end
				end
			end
		end
	end

	initial begin
		errors = 0;
		cycles = 0;
		no_idle = 1'b0;
		hold_req = 1'b0;
		in_xfer = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = lbpc_pkg::REG_WINDOW_LEFT;
		cfg_wr_data = '0;
		vin.valid = 1'b0;
		vin.vertex_x = '0;
		vin.vertex_y = '0;
		vin.first_vertex = 1'b0;
		vin.last_vertex = 1'b0;
		vout.ready = 1'b0;
		win_l = lbpc_pkg::WIN_LO_RESET;
		win_r = lbpc_pkg::WIN_HI_RESET;
		win_b = lbpc_pkg::WIN_LO_RESET;
		win_t = lbpc_pkg::WIN_HI_RESET;
		last_x = 0;
		last_y = 0;
		open_x = 0;
		open_y = 0;
		have_output = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(posedge clk);

		// Directed part against the default window.
		add_vertex(10, 10, 1, 0);
		add_vertex(100, 10, 0, 0);
		add_vertex(100, 100, 0, 0);
		add_vertex(10, 10, 0, 1);
		add_vertex(-32768, -32768, 1, 0);
		add_vertex(32767, -32768, 0, 0);
		add_vertex(32767, 32767, 0, 0);
		add_vertex(-32768, 32767, 0, 0);
		add_vertex(-32768, -32768, 0, 1);
		// Entirely outside, so the empty marker comes out.
		add_vertex(300, 300, 1, 0);
		add_vertex(400, 300, 0, 0);
		add_vertex(300, 300, 0, 1);
		// Both marks on one vertex.
		add_vertex(5, 5, 1, 1);
		// A vertex after a close with no start mark forms an edge from the close.
		add_vertex(50, 50, 0, 0);
		add_vertex(200, -20, 0, 0);
		add_vertex(50, 50, 0, 1);
		// An axis-parallel edge outside and diagonals across the window corners.
		add_vertex(-10, 50, 1, 0);
		add_vertex(-10, 200, 0, 0);
		add_vertex(128, 300, 0, 0);
		add_vertex(300, 128, 0, 0);
		add_vertex(-10, 50, 0, 1);
		add_vertex(0, 255, 1, 0);
		add_vertex(255, 0, 0, 0);
		add_vertex(0, 255, 0, 1);
		drain();
		set_window(lbpc_pkg::WIN_LO_RESET, lbpc_pkg::WIN_HI_RESET,
			lbpc_pkg::WIN_LO_RESET, lbpc_pkg::WIN_HI_RESET);
		add_random_items(40);
		drain();

		set_window(-32768, 32767, -32768, 32767);
		hold_req = 1'b1;
		add_random_items(40);
		drain();

		// Inverted window.
		set_window(200, 50, 180, 20);
		add_random_items(40);
		drain();

		set_window(-100, 100, -50, 50);
		no_idle = 1'b1;
		add_random_items(40);
		drain();
		no_idle = 1'b0;

		set_window(0, 0, 0, 0);
		add_random_items(30);
		drain();

		set_window(32767, 32767, -32768, -32768);
		add_random_items(20);
		drain();

		if (errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

>>> sim.f
sv/lbpc_pkg.sv
sv/lbpc_if.sv
sv/lbpc_div.sv
sv/liang_barsky_polygon_clip_unit.sv
sv/lbpc_chk.sv
tb/tb.sv
